@@ design/krt_pkg.sv @@
// shared types and codes for the keyed registration table
// no dependencies
package krt_pkg;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int KEY_PORT_BITS    = 32;
   localparam int HANDLE_PORT_BITS = 16;
   localparam int COUNT_PORT_BITS  = 8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_DONE
   } krt_state_type;

   typedef struct packed {
      logic [1:0]                    status;
      logic [HANDLE_PORT_BITS-1:0]   found_handle;
      logic [COUNT_PORT_BITS-1:0]    entry_count;
   } krt_rsp_type;

endpackage

@@ design/keyed_registration_table_unit.sv @@
// Keyed registration table: up to ENTRIES key/handle pairs in one memory pair,
// one command per transaction (lookup, insert, remove) and one response each.
// A command scans the occupied entries one per cycle through the single read
// port and one key comparator; a remove with a match then moves the last entry
// into the freed slot. That scan sets the rate: the next transaction can be
// taken from the cycle in which the response first shows in the output
// register.
module keyed_registration_table_unit
   import krt_pkg::*;
#(
   parameter int ENTRIES     = 128,
   parameter int KEY_BITS    = 32,
   parameter int HANDLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [KEY_PORT_BITS-1:0]    req_key,
   input  logic [HANDLE_PORT_BITS-1:0] req_handle,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [HANDLE_PORT_BITS-1:0] rsp_found_handle,
   output logic [COUNT_PORT_BITS-1:0]  rsp_entry_count
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
   localparam int HW = (HANDLE_BITS < HANDLE_PORT_BITS) ? HANDLE_BITS : HANDLE_PORT_BITS;

   logic          idle;
   logic          done;
   logic          out_free;
   logic          req_accept;
   krt_rsp_type   rsp;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [KW-1:0] mem_rd_key;
   logic [HW-1:0] mem_rd_handle;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [KW-1:0] mem_wr_key;
   logic [HW-1:0] mem_wr_handle;

   logic          rsp_valid_ff;
   krt_rsp_type   rsp_data_ff;

   assign req_stall  = !idle;
   assign req_accept = req_valid && idle;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   krt_ctrl #(
      .ENTRIES (ENTRIES),
      .CW      (CW),
      .AW      (AW),
      .KW      (KW),
      .HW      (HW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_cmd       (req_cmd),
      .req_key       (req_key),
      .req_handle    (req_handle),
      .out_free      (out_free),
      .idle          (idle),
      .done          (done),
      .rsp           (rsp),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_key    (mem_rd_key),
      .mem_rd_handle (mem_rd_handle),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_key    (mem_wr_key),
      .mem_wr_handle (mem_wr_handle)
   );

   krt_store #(
      .DEPTH (ENTRIES),
      .AW    (AW),
      .KW    (KW),
      .HW    (HW)
   ) u_store (
      .clock     (clock),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_key    (mem_rd_key),
      .rd_handle (mem_rd_handle),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_key    (mem_wr_key),
      .wr_handle (mem_wr_handle)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (done && out_free) || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (done && out_free) rsp_data_ff <= rsp;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_found_handle = rsp_data_ff.found_handle;
   assign rsp_entry_count  = rsp_data_ff.entry_count;

endmodule

@@ design/krt_store.sv @@
// key and handle memories, one registered read port and one write port
// no package dependencies
module krt_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int KW    = 32,
   parameter int HW    = 16
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [KW-1:0] rd_key,
   output logic [HW-1:0] rd_handle,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [KW-1:0] wr_key,
   input  logic [HW-1:0] wr_handle
);

   logic [KW-1:0] key_mem [DEPTH];
   logic [HW-1:0] handle_mem [DEPTH];
   logic [KW-1:0] rd_key_ff;
   logic [HW-1:0] rd_handle_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]    <= wr_key;
         handle_mem[wr_addr] <= wr_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff    <= key_mem[rd_addr];
         rd_handle_ff <= handle_mem[rd_addr];
      end
   end

   assign rd_key    = rd_key_ff;
   assign rd_handle = rd_handle_ff;

endmodule

@@ design/krt_ctrl.sv @@
// command sequencer: linear key scan through one compare unit, insert append,
// remove with last-entry move; uses krt_pkg
module krt_ctrl
   import krt_pkg::*;
#(
   parameter int ENTRIES = 128,
   parameter int CW      = 8,
   parameter int AW      = 7,
   parameter int KW      = 32,
   parameter int HW      = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_accept,
   input  logic [1:0]                  req_cmd,
   input  logic [KEY_PORT_BITS-1:0]    req_key,
   input  logic [HANDLE_PORT_BITS-1:0] req_handle,
   input  logic                        out_free,
   output logic                        idle,
   output logic                        done,
   output krt_rsp_type                 rsp,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   input  logic [KW-1:0]               mem_rd_key,
   input  logic [HW-1:0]               mem_rd_handle,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [KW-1:0]               mem_wr_key,
   output logic [HW-1:0]               mem_wr_handle
);

   krt_state_type  state_ff, state_in;
   logic [1:0]     cmd_ff;
   logic [KW-1:0]  key_ff;
   logic [HW-1:0]  hdl_ff;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  rd_idx_ff;
   logic           cmp_vld_ff;
   logic [AW-1:0]  cmp_idx_ff;
   logic           hit_ff;
   logic [AW-1:0]  slot_ff;
   logic [HW-1:0]  got_ff;
   logic [1:0]     status_ff;

   logic           hit;
   logic           scan_more;
   logic           issue;
   logic           scan_end;
   logic           full;
   logic [CW-1:0]  last;
   logic           insert_ok;

   assign hit       = (state_ff == S_SCAN) && cmp_vld_ff && (mem_rd_key == key_ff);
   assign scan_more = rd_idx_ff < count_ff;
   assign issue     = (state_ff == S_SCAN) && scan_more && !hit;
   assign scan_end  = hit || (!scan_more && !cmp_vld_ff);
   assign full      = count_ff == CW'(ENTRIES);
   assign last      = count_ff - CW'(1);
   assign insert_ok = (cmd_ff == CMD_INSERT) && !full && !hit_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_accept) state_in = S_SCAN;
         S_SCAN:    if (scan_end) state_in = S_DECIDE;
         S_DECIDE: begin
            if (cmd_ff == CMD_REMOVE && hit_ff) state_in = S_MOVE_RD;
            else state_in = S_DONE;
         end
         S_MOVE_RD: state_in = S_MOVE_WR;
         S_MOVE_WR: state_in = S_DONE;
         S_DONE:    if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      idle          = state_ff == S_IDLE;
      done          = state_ff == S_DONE;
      mem_rd_en     = issue || (state_ff == S_MOVE_RD);
      mem_rd_addr   = (state_ff == S_MOVE_RD) ? last[AW-1:0] : rd_idx_ff[AW-1:0];
      mem_wr_en     = ((state_ff == S_DECIDE) && insert_ok) || (state_ff == S_MOVE_WR);
      if (state_ff == S_MOVE_WR) begin
         // last entry fills the freed slot
         mem_wr_addr   = slot_ff;
         mem_wr_key    = mem_rd_key;
         mem_wr_handle = mem_rd_handle;
      end else begin
         mem_wr_addr   = count_ff[AW-1:0];
         mem_wr_key    = key_ff;
         mem_wr_handle = hdl_ff;
      end
      rsp.status       = status_ff;
      rsp.found_handle = (hit_ff && (cmd_ff == CMD_LOOKUP || cmd_ff == CMD_REMOVE)) ?
                         HANDLE_PORT_BITS'(got_ff) : '0;
      rsp.entry_count  = COUNT_PORT_BITS'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= issue;
         if (req_accept && state_ff == S_IDLE) hit_ff <= 1'b0;
         else if (hit) hit_ff <= 1'b1;
         if (state_ff == S_DECIDE && insert_ok) count_ff <= count_ff + CW'(1);
         else if (state_ff == S_MOVE_WR) count_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && state_ff == S_IDLE) begin
         cmd_ff    <= req_cmd;
         key_ff    <= req_key[KW-1:0];
         hdl_ff    <= req_handle[HW-1:0];
         rd_idx_ff <= '0;
      end
      if (issue) begin
         rd_idx_ff  <= rd_idx_ff + CW'(1);
         cmp_idx_ff <= rd_idx_ff[AW-1:0];
      end
      if (hit) begin
         slot_ff <= cmp_idx_ff;
         got_ff  <= mem_rd_handle;
      end
      if (state_ff == S_DECIDE) begin
         unique case (cmd_ff)
            CMD_LOOKUP: status_ff <= hit_ff ? ST_OK : ST_NOT_FOUND;
            CMD_INSERT: status_ff <= full ? ST_FULL : (hit_ff ? ST_DUPLICATE : ST_OK);
            CMD_REMOVE: status_ff <= hit_ff ? ST_OK : ST_NOT_FOUND;
            default:    status_ff <= ST_OK;
         endcase
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count above capacity");

   a_move_needs_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE_RD |-> hit_ff && count_ff != '0)
      else $error("entry move without a matched entry");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cmp_vld_ff) |-> CW'(cmp_idx_ff) < count_ff)
      else $error("compare on an unoccupied entry");

endmodule

@@ sim/testbench.sv @@
// testbench for keyed_registration_table_unit: directed and random lookup, insert and
// remove traffic with random gaps and stalls, checked against an in-bench table model
// depends on design/krt_pkg.sv and design/keyed_registration_table_unit.sv
module testbench;
   import krt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 128;
   localparam int POOL_SIZE   = 200;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]                  cmd;
      logic [KEY_PORT_BITS-1:0]    key;
      logic [HANDLE_PORT_BITS-1:0] handle;
   } table_cmd_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_cmd = CMD_LOOKUP;
   logic [KEY_PORT_BITS-1:0]    req_key = '0;
   logic [HANDLE_PORT_BITS-1:0] req_handle = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_status;
   logic [HANDLE_PORT_BITS-1:0] rsp_found_handle;
   logic [COUNT_PORT_BITS-1:0]  rsp_entry_count;

   keyed_registration_table_unit #(
      .ENTRIES(TABLE_DEPTH),
      .KEY_BITS(KEY_PORT_BITS),
      .HANDLE_BITS(HANDLE_PORT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_key(req_key),
      .req_handle(req_handle),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found_handle(rsp_found_handle),
      .rsp_entry_count(rsp_entry_count)
   );

   always #5 clock = ~clock;

   // predicted table contents
   logic [KEY_PORT_BITS-1:0]    table_key [TABLE_DEPTH];
   logic [HANDLE_PORT_BITS-1:0] table_handle [TABLE_DEPTH];
   int                          table_count = 0;
   int                          peak_count = 0;

   table_cmd_type pending_cmds[$];
   krt_rsp_type   expected_rsp[$];

   int total_cmds = 0;
   int accepted_cmds = 0;
   int error_count = 0;
   int status_tally [4] = '{0, 0, 0, 0};

   function automatic int find_key(logic [KEY_PORT_BITS-1:0] key);
      int i;
      for (i = 0; i < table_count; i++) begin
         if (table_key[i] == key) return i;
      end
      return table_count;
   endfunction

   function automatic krt_rsp_type apply_command(table_cmd_type c);
      krt_rsp_type r;
      int slot;
      r.status = ST_OK;
      r.found_handle = '0;
      slot = find_key(c.key);
      case (c.cmd)
         CMD_LOOKUP: begin
            if (slot < table_count) r.found_handle = table_handle[slot];
            else r.status = ST_NOT_FOUND;
         end
         CMD_INSERT: begin
            // fullness wins over duplicate
            if (table_count >= TABLE_DEPTH) r.status = ST_FULL;
            else if (slot < table_count) r.status = ST_DUPLICATE;
            else begin
               table_key[table_count] = c.key;
               table_handle[table_count] = c.handle;
               table_count++;
            end
         end
         CMD_REMOVE: begin
            if (slot < table_count) begin
               r.found_handle = table_handle[slot];
               table_count--;
               // last entry fills the hole
               table_key[slot] = table_key[table_count];
               table_handle[slot] = table_handle[table_count];
            end else r.status = ST_NOT_FOUND;
         end
         default: ;
      endcase
      r.entry_count = COUNT_PORT_BITS'(table_count);
      if (table_count > peak_count) peak_count = table_count;
      return r;
   endfunction

   function automatic int pick_gap(int longest);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, longest);
   endfunction

   task automatic push_cmd(logic [1:0] cmd, logic [KEY_PORT_BITS-1:0] key,
                           logic [HANDLE_PORT_BITS-1:0] handle);
      table_cmd_type c;
      c.cmd = cmd;
      c.key = key;
      c.handle = handle;
      pending_cmds.push_back(c);
   endtask

   // driver
   int send_gap = 0;
   int send_calm = 0;
   always @(posedge clock) begin
      table_cmd_type c;
      krt_rsp_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            c.cmd = req_cmd;
            c.key = req_key;
            c.handle = req_handle;
            r = apply_command(c);
            expected_rsp.push_back(r);
            accepted_cmds++;
         end
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_cmd <= c.cmd;
            req_key <= c.key;
            req_handle <= c.handle;
            if (send_calm > 0) begin
               send_gap <= 0;
               send_calm <= send_calm - 1;
            end else begin
               send_gap <= pick_gap(80);
               if ($urandom_range(0, 39) == 0) send_calm <= $urandom_range(20, 50);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and response stall
   int stall_left = 0;
   always @(posedge clock) begin
      krt_rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            status_tally[rsp_status]++;
            if (expected_rsp.size() == 0) begin
               error_count++;
               $display("%0t: response with nothing outstanding: status %0d handle %h count %0d",
                        $time, rsp_status, rsp_found_handle, rsp_entry_count);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_status !== e.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, e.status, rsp_status);
               end
               if (rsp_found_handle !== e.found_handle) begin
                  error_count++;
                  $display("%0t: found_handle expected %h actual %h",
                           $time, e.found_handle, rsp_found_handle);
               end
               if (rsp_entry_count !== e.entry_count) begin
                  error_count++;
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, e.entry_count, rsp_entry_count);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 29) == 0) begin
            rsp_stall <= 1'b0;
            stall_left <= 300;
         end else if ($urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(1, 20);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= pick_gap(150);
         end
      end
   end

   initial begin
      logic [KEY_PORT_BITS-1:0] key_pool [POOL_SIZE];
      logic [KEY_PORT_BITS-1:0] k;
      int rep;
      int i;
      int r;
      int fresh;

      // directed: empty table, key and handle extremes, duplicate, move on remove
      push_cmd(CMD_LOOKUP, 32'h0000_0000, 16'hffff);
      push_cmd(CMD_REMOVE, 32'hffff_ffff, 16'h0000);
      push_cmd(CMD_UNUSED, 32'hffff_ffff, 16'hffff);
      push_cmd(CMD_INSERT, 32'h0000_0000, 16'hffff);
      push_cmd(CMD_INSERT, 32'hffff_ffff, 16'h0000);
      push_cmd(CMD_INSERT, 32'h0000_0000, 16'h1234);
      push_cmd(CMD_LOOKUP, 32'h0000_0000, 16'h0000);
      push_cmd(CMD_LOOKUP, 32'hffff_ffff, 16'hffff);
      push_cmd(CMD_LOOKUP, 32'h0000_0005, 16'h0000);
      push_cmd(CMD_INSERT, 32'h8000_0001, 16'h8000);
      push_cmd(CMD_REMOVE, 32'h0000_0000, 16'h5555);
      push_cmd(CMD_LOOKUP, 32'h8000_0001, 16'haaaa);
      push_cmd(CMD_LOOKUP, 32'h0000_0000, 16'h0000);
      push_cmd(CMD_UNUSED, 32'h5a5a_5a5a, 16'ha5a5);
      push_cmd(CMD_REMOVE, 32'hffff_ffff, 16'h0000);
      push_cmd(CMD_REMOVE, 32'h8000_0001, 16'h0000);
      push_cmd(CMD_REMOVE, 32'h8000_0001, 16'hffff);
      push_cmd(CMD_INSERT, 32'ha5a5_a5a5, 16'h5a5a);
      push_cmd(CMD_LOOKUP, 32'ha5a5_a5a4, 16'h0000);

      for (rep = 0; rep < 3; rep++) begin
         for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
         // churn on a handful of keys so hits and duplicates are common
         for (i = 0; i < 120; i++) begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 15)];
            if (r < 40) push_cmd(CMD_INSERT, k, 16'($urandom()));
            else if (r < 70) push_cmd(CMD_LOOKUP, k, 16'($urandom()));
            else if (r < 95) push_cmd(CMD_REMOVE, k, 16'($urandom()));
            else push_cmd(CMD_UNUSED, k, 16'($urandom()));
         end
         // fill past capacity, mostly fresh keys
         fresh = 16;
         for (i = 0; i < 180; i++) begin
            r = $urandom_range(0, 99);
            if (r < 90) begin
               if ($urandom_range(0, 9) != 0 && fresh < POOL_SIZE) begin
                  k = key_pool[fresh];
                  fresh++;
               end else k = key_pool[$urandom_range(0, fresh - 1)];
               push_cmd(CMD_INSERT, k, 16'($urandom()));
            end else if (r < 97) begin
               push_cmd(CMD_LOOKUP, key_pool[$urandom_range(0, fresh - 1)], 16'($urandom()));
            end else begin
               push_cmd(CMD_REMOVE, key_pool[$urandom_range(0, fresh - 1)], 16'($urandom()));
            end
         end
         // drain
         for (i = 0; i < 180; i++) begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 70) push_cmd(CMD_REMOVE, k, 16'($urandom()));
            else if (r < 90) push_cmd(CMD_LOOKUP, k, 16'($urandom()));
            else if (r < 95) push_cmd(CMD_INSERT, k, 16'($urandom()));
            else push_cmd(CMD_UNUSED, $urandom(), 16'($urandom()));
         end
      end
      total_cmds = pending_cmds.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cmds < total_cmds) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 10) @(posedge clock);

      $display("ran %0d commands: %0d ok, %0d not found, %0d duplicate, %0d full",
               total_cmds, status_tally[ST_OK], status_tally[ST_NOT_FOUND],
               status_tally[ST_DUPLICATE], status_tally[ST_FULL]);
      $display("peak occupancy %0d of %0d entries, %0d mismatches",
               peak_count, TABLE_DEPTH, error_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout: %0d of %0d commands accepted, %0d responses outstanding",
               accepted_cmds, total_cmds, expected_rsp.size());
      $display("testbench: done, errors");
      $finish;
   end

endmodule
